@@ rtl/longest_increasing_subsequence_defines.svh @@
// Assertion macros shared by the longest increasing subsequence RTL.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LIS_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("LIS assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LIS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("LIS assertion failed: next-cycle implication");

`endif

@@ rtl/lis_pkg.sv @@
// Package with the word types and token control type of the LIS block.
package lis_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned ReportWidth = 9;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  start_req;
  } item_word_t;

  typedef struct packed {
    logic [ReportWidth-1:0] ending_length;
    logic [ReportWidth-1:0] best_length;
    logic                   overflow;
  } result_word_t;

  typedef struct packed {
    logic valid;
    logic start;
    logic ovf;
  } tok_ctl_t;

endpackage

@@ rtl/lis_cell.sv @@
// One cell of the chain: holds one stored value and length and passes the token on.
module lis_cell #(
  parameter int unsigned VB      = 32,
  parameter int unsigned CW      = 9,
  parameter int unsigned CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lis_pkg::tok_ctl_t in_ctl,
  input  logic [VB-1:0]     in_value,
  input  logic [CW-1:0]     in_idx,
  input  logic [CW-1:0]     in_prior,
  output lis_pkg::tok_ctl_t out_ctl,
  output logic [VB-1:0]     out_value,
  output logic [CW-1:0]     out_idx,
  output logic [CW-1:0]     out_prior
);

  localparam logic [CW-1:0] MyId = CW'(CELL_ID);

  logic [VB-1:0] stored_value;
  logic [CW-1:0] stored_len;
  logic          active;
  logic          beats;

  assign active = in_ctl.valid && !in_ctl.ovf;
  assign beats  = ($signed(stored_value) < $signed(in_value)) && (stored_len > in_prior);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= in_value;
      out_idx   <= in_idx;
      out_prior <= in_prior;
      if (active && in_idx == MyId) begin
        stored_value <= in_value;
        stored_len   <= in_prior + CW'(1);
      end else if (active && in_idx > MyId && beats) begin
        out_prior <= stored_len;
      end
    end
  end

endmodule

@@ rtl/lis_tail.sv @@
// Output stage: forms the ending length, tracks the best length and holds the result word.
module lis_tail #(
  parameter int unsigned CW = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  lis_pkg::tok_ctl_t     in_ctl,
  input  logic [CW-1:0]         in_prior,
  output logic                  result_valid,
  output lis_pkg::result_word_t result
);

  logic [CW-1:0] best_so_far;
  logic [CW-1:0] best_next;
  logic [CW-1:0] best_base;
  logic [CW-1:0] ending;

  always_comb begin
    ending    = in_ctl.ovf ? '0 : in_prior + CW'(1);
    best_base = in_ctl.start ? '0 : best_so_far;
    best_next = (!in_ctl.ovf && ending > best_base) ? ending : best_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      best_so_far  <= '0;
    end else if (en) begin
      result_valid <= in_ctl.valid;
      if (in_ctl.valid) begin
        best_so_far <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_ctl.valid) begin
      result.ending_length <= lis_pkg::ReportWidth'(ending);
      result.best_length   <= lis_pkg::ReportWidth'(best_next);
      result.overflow      <= in_ctl.ovf;
    end
  end

endmodule

@@ rtl/longest_increasing_subsequence.sv @@
// Top level of the streaming longest increasing subsequence block.
//
//   Channel   Handshake                   Word type
//   item      item_valid / item_stall     lis_pkg::item_word_t
//   result    result_valid / result_stall lis_pkg::result_word_t
//
// One word is taken per cycle while the result channel is not stalled; each
// result is registered through the cell chain and then the output stage.
// Reset clears the token valid bits, the item count, the best length and the
// overflow flag; stored cell entries are only read once written in a sequence.
// A stalled result freezes the whole chain and stalls the item channel.
module longest_increasing_subsequence #(
  parameter int unsigned MAX_ITEMS  = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  lis_pkg::item_word_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lis_pkg::result_word_t result
);

  `include "longest_increasing_subsequence_defines.svh"

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VB = VALUE_BITS;
  localparam logic [CW-1:0] Full = CW'(MAX_ITEMS);

  logic              en;
  logic              accept;
  logic [CW-1:0]     item_count;
  logic [CW-1:0]     count_base;
  logic              overflowed;
  logic              ovf_now;
  logic [VB-1:0]     key;

  lis_pkg::tok_ctl_t ctl_chain   [0:MAX_ITEMS];
  logic [VB-1:0]     value_chain [0:MAX_ITEMS];
  logic [CW-1:0]     idx_chain   [0:MAX_ITEMS];
  logic [CW-1:0]     prior_chain [0:MAX_ITEMS];

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;
  assign accept     = item_valid && en;

  generate
    if (VB <= lis_pkg::ValueWidth) begin : g_key_narrow
      assign key = item.value[VB-1:0];
    end else begin : g_key_wide
      assign key = {{(VB - lis_pkg::ValueWidth){item.value[lis_pkg::ValueWidth-1]}},
                    item.value};
    end
  endgenerate

  always_comb begin
    count_base = item.start_req ? '0 : item_count;
    ovf_now    = (count_base == Full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      overflowed <= 1'b0;
    end else if (accept) begin
      item_count <= ovf_now ? count_base : count_base + CW'(1);
      overflowed <= ovf_now;
    end
  end

  always_comb begin
    ctl_chain[0].valid = accept;
    ctl_chain[0].start = item.start_req;
    ctl_chain[0].ovf   = ovf_now;
    value_chain[0]     = key;
    idx_chain[0]       = count_base;
    prior_chain[0]     = '0;
  end

  generate
    for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
      lis_cell #(
        .VB      (VB),
        .CW      (CW),
        .CELL_ID (c)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_ctl    (ctl_chain[c]),
        .in_value  (value_chain[c]),
        .in_idx    (idx_chain[c]),
        .in_prior  (prior_chain[c]),
        .out_ctl   (ctl_chain[c+1]),
        .out_value (value_chain[c+1]),
        .out_idx   (idx_chain[c+1]),
        .out_prior (prior_chain[c+1])
      );
    end
  endgenerate

  lis_tail #(
    .CW (CW)
  ) u_tail (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_ctl       (ctl_chain[MAX_ITEMS]),
    .in_prior     (prior_chain[MAX_ITEMS]),
    .result_valid (result_valid),
    .result       (result)
  );

  `LIS_ASSERT_IMPLY(a_stall_backs_up, result_valid && result_stall, item_stall)
  `LIS_ASSERT_IMPLY(a_ovf_zero_len, result_valid && result.overflow, result.ending_length == '0)
  `LIS_ASSERT_NEXT(a_start_clears_ovf, accept && item.start_req, !overflowed)

endmodule
